// File: src/mrr_pkg.sv
// Package: small-case limits and shared constants for the Miller-Rabin round block.
`default_nettype none

package mrr_pkg;

    // Candidates up to this value are decided without exponentiation
    localparam int unsigned N_TWO   = 2;
    localparam int unsigned N_THREE = 3;
    localparam int unsigned N_FOUR  = 4;

endpackage : mrr_pkg

`default_nettype wire

// File: src/miller_rabin_round.sv
// Top level: one Miller-Rabin strong-probable-prime round on a shared modular multiplier.
//
// Input channel (in_valid / in_ready) transfers a candidate n and a witness base a;
// only the low WIDTH bits of each are used. Output channel (out_valid / out_ready)
// transfers one result per input: probable_prime and trivially_decided.
// Candidates of 4 or less are settled straight away: the sequencer goes to S_DONE, which
// registers out_valid once the output register is free. Otherwise the block counts the
// trailing zeros of n-1 (one bit a cycle), reduces the witness modulo n, runs
// right-to-left square-and-multiply over q and then squares up to k-1 more times.
// Every modular product goes through one shift-add multiplier that takes one multiplier
// bit a cycle with a conditional subtract of n or 2n.
// The count of products, and so the time per item, depends on the bits of n-1.
// The block works on one item at a time: in_ready is high only when the sequencer is
// idle. A finished result sits in the output register; the next item may be taken
// while it waits, but a new result is held in the sequencer until the register frees.
// Reset clears the sequencer and the output valid flag; no result is pending after it.
`default_nettype none

module miller_rabin_round
    import mrr_pkg::*;
#(
    parameter int WIDTH = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] candidate,
    input  wire logic [31:0] witness,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             probable_prime,
    output logic             trivially_decided
);

    localparam int KW = $clog2(WIDTH);
    localparam int CW = $clog2(WIDTH + 1);
    localparam int TW = WIDTH + 2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TZ,
        S_RED,
        S_PMUL,
        S_PSQ,
        S_CHECK,
        S_SQ,
        S_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [WIDTH-1:0]   n_reg, n_next;
    logic [WIDTH-1:0]   nm1_reg, nm1_next;
    logic [WIDTH-1:0]   a_reg, a_next;
    logic [WIDTH-1:0]   q_reg, q_next;
    logic [KW-1:0]      k_reg, k_next;
    logic [WIDTH-1:0]   acc_reg, acc_next;
    logic [WIDTH-1:0]   sq_reg, sq_next;
    logic [WIDTH-1:0]   mx_reg, mx_next;
    logic [WIDTH-1:0]   my_reg, my_next;
    logic [WIDTH-1:0]   mr_reg, mr_next;
    logic [CW-1:0]      mcnt_reg, mcnt_next;
    logic               res_prime_reg, res_prime_next;
    logic               res_triv_reg, res_triv_next;
    logic               out_valid_reg, out_valid_next;
    logic               prime_out_reg, prime_out_next;
    logic               triv_out_reg, triv_out_next;

    logic [WIDTH-1:0]   n_in;
    logic [TW-1:0]      t_sum;
    logic [TW-1:0]      n1_ext;
    logic [TW-1:0]      n2_ext;
    logic [TW-1:0]      t_red;
    logic [WIDTH-1:0]   mstep;
    logic               mul_done;
    logic               in_xfer;

    assign n_in     = candidate[WIDTH-1:0];
    assign in_ready = (state_reg == S_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign mul_done = (mcnt_reg == '0);

    // Shift-add step: r = 2r + bit*x, then bring back below n
    assign n1_ext = {2'b00, n_reg};
    assign n2_ext = {1'b0, n_reg, 1'b0};
    assign t_sum  = {1'b0, mr_reg, 1'b0} + (my_reg[WIDTH-1] ? {2'b00, mx_reg} : '0);

    always_comb
    begin
        priority if (t_sum >= n2_ext)
        begin
            t_red = t_sum - n2_ext;
        end
        else if (t_sum >= n1_ext)
        begin
            t_red = t_sum - n1_ext;
        end
        else
        begin
            t_red = t_sum;
        end
    end

    assign mstep = t_red[WIDTH-1:0];

    // Sequencer and data path next-state logic
    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        nm1_next       = nm1_reg;
        a_next         = a_reg;
        q_next         = q_reg;
        k_next         = k_reg;
        acc_next       = acc_reg;
        sq_next        = sq_reg;
        mx_next        = mx_reg;
        my_next        = my_reg;
        mr_next        = mr_reg;
        mcnt_next      = mcnt_reg;
        res_prime_next = res_prime_reg;
        res_triv_next  = res_triv_reg;
        out_valid_next = out_valid_reg;
        prime_out_next = prime_out_reg;
        triv_out_next  = triv_out_reg;

        // Drop the result once the receiver takes it
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // Advance the multiplier one bit while it runs
        if (!mul_done)
        begin
            mr_next   = mstep;
            my_next   = my_reg << 1;
            mcnt_next = mcnt_reg - CW'(1);
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    n_next   = n_in;
                    nm1_next = n_in - WIDTH'(1);
                    q_next   = n_in - WIDTH'(1);
                    a_next   = witness[WIDTH-1:0];
                    k_next   = '0;
                    priority if (n_in <= WIDTH'(1) || n_in == WIDTH'(N_FOUR))
                    begin
                        res_prime_next = 1'b0;
                        res_triv_next  = 1'b1;
                        state_next     = S_DONE;
                    end
                    else if (n_in == WIDTH'(N_TWO) || n_in == WIDTH'(N_THREE))
                    begin
                        res_prime_next = 1'b1;
                        res_triv_next  = 1'b1;
                        state_next     = S_DONE;
                    end
                    else
                    begin
                        res_triv_next = 1'b0;
                        state_next    = S_TZ;
                    end
                end
            end

            // Strip trailing zeros of n-1, then reduce the witness as 1*a mod n
            S_TZ:
            begin
                if (!q_reg[0])
                begin
                    q_next = q_reg >> 1;
                    k_next = k_reg + KW'(1);
                end
                else
                begin
                    mx_next    = WIDTH'(1);
                    my_next    = a_reg;
                    mr_next    = '0;
                    mcnt_next  = CW'(WIDTH);
                    state_next = S_RED;
                end
            end

            // Reduced base ready: q is odd, so multiply first
            S_RED:
            begin
                if (mul_done)
                begin
                    sq_next    = mr_reg;
                    acc_next   = WIDTH'(1);
                    mx_next    = WIDTH'(1);
                    my_next    = mr_reg;
                    mr_next    = '0;
                    mcnt_next  = CW'(WIDTH);
                    state_next = S_PMUL;
                end
            end

            // Exponent bit set: take the product, then square unless q runs out
            S_PMUL:
            begin
                if (mul_done)
                begin
                    acc_next = mr_reg;
                    q_next   = q_reg >> 1;
                    if ((q_reg >> 1) == '0)
                    begin
                        state_next = S_CHECK;
                    end
                    else
                    begin
                        mx_next    = sq_reg;
                        my_next    = sq_reg;
                        mr_next    = '0;
                        mcnt_next  = CW'(WIDTH);
                        state_next = S_PSQ;
                    end
                end
            end

            // Square done: multiply on a set bit, square again on a clear one
            S_PSQ:
            begin
                if (mul_done)
                begin
                    sq_next   = mr_reg;
                    mr_next   = '0;
                    mcnt_next = CW'(WIDTH);
                    if (q_reg[0])
                    begin
                        mx_next    = acc_reg;
                        my_next    = mr_reg;
                        state_next = S_PMUL;
                    end
                    else
                    begin
                        q_next  = q_reg >> 1;
                        mx_next = mr_reg;
                        my_next = mr_reg;
                    end
                end
            end

            // First test on a^q mod n
            S_CHECK:
            begin
                priority if (acc_reg == WIDTH'(1) || acc_reg == nm1_reg)
                begin
                    res_prime_next = 1'b1;
                    state_next     = S_DONE;
                end
                else if (k_reg <= KW'(1))
                begin
                    res_prime_next = 1'b0;
                    state_next     = S_DONE;
                end
                else
                begin
                    k_next     = k_reg - KW'(1);
                    mx_next    = acc_reg;
                    my_next    = acc_reg;
                    mr_next    = '0;
                    mcnt_next  = CW'(WIDTH);
                    state_next = S_SQ;
                end
            end

            // Further squarings: n-1 passes, 1 or exhaustion fails
            S_SQ:
            begin
                if (mul_done)
                begin
                    acc_next = mr_reg;
                    priority if (mr_reg == WIDTH'(1))
                    begin
                        res_prime_next = 1'b0;
                        state_next     = S_DONE;
                    end
                    else if (mr_reg == nm1_reg)
                    begin
                        res_prime_next = 1'b1;
                        state_next     = S_DONE;
                    end
                    else if (k_reg <= KW'(1))
                    begin
                        res_prime_next = 1'b0;
                        state_next     = S_DONE;
                    end
                    else
                    begin
                        k_next    = k_reg - KW'(1);
                        mx_next   = mr_reg;
                        my_next   = mr_reg;
                        mr_next   = '0;
                        mcnt_next = CW'(WIDTH);
                    end
                end
            end

            // Hold the result until the output register is free
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    prime_out_next = res_prime_reg;
                    triv_out_next  = res_triv_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, data path and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mcnt_reg      <= mcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        nm1_reg       <= nm1_next;
        a_reg         <= a_next;
        q_reg         <= q_next;
        k_reg         <= k_next;
        acc_reg       <= acc_next;
        sq_reg        <= sq_next;
        mx_reg        <= mx_next;
        my_reg        <= my_next;
        mr_reg        <= mr_next;
        res_prime_reg <= res_prime_next;
        res_triv_reg  <= res_triv_next;
        prime_out_reg <= prime_out_next;
        triv_out_reg  <= triv_out_next;
    end

    assign out_valid         = out_valid_reg;
    assign probable_prime    = prime_out_reg;
    assign trivially_decided = triv_out_reg;

    // The multiplier never runs while the block waits for an item
    a_idle_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (mcnt_reg == '0))
        else $error("multiplier busy while idle");

    // Partial product stays reduced below n throughout a product
    a_mr_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (mcnt_reg != '0) |-> (mr_reg < n_reg))
        else $error("partial product not reduced");

    // Value under test is reduced when it is checked
    a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK) |-> (acc_reg < n_reg))
        else $error("exponentiation result not reduced");

    // A result appears only from the completion state
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside completion");

endmodule : miller_rabin_round

`default_nettype wire
